>>> design/sitda_pkg.sv
// sitda_pkg: shared types and constants for the signed integer to decimal text core
// no dependencies; imported by every module of the core
package sitda_pkg;

    localparam int VALUE_W        = 32;
    localparam int DIGITS         = 10;
    localparam int DIGIT_W        = 4;
    localparam int BITS_PER_STAGE = 4;
    localparam int DD_STAGES      = VALUE_W / BITS_PER_STAGE;
    localparam int CHAR_W         = 8;
    localparam int LEN_W          = 4;
    localparam int IDX_W          = 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    typedef logic [DIGITS-1:0][DIGIT_W-1:0] t_digits;

    // payload moving through the double-dabble stages
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] bin;
        t_digits            bcd;
    } t_conv;

    // converted number ready for serializing
    typedef struct packed {
        logic             neg;
        t_digits          bcd;
        logic [IDX_W-1:0] ndig;
        logic [LEN_W-1:0] len;
    } t_num;

endpackage

>>> design/sitda_abs.sv
// sitda_abs: first pipeline stage, sign and 32-bit magnitude of the request
// depends on sitda_pkg
module sitda_abs
    import sitda_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output t_conv              o_data
);

    logic  r_valid;
    t_conv r_data;
    t_conv n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data.neg = i_value[VALUE_W-1];
        // two's complement negate gives the full magnitude, most negative value included
        n_data.bin = i_value[VALUE_W-1] ? (~i_value + 1'b1) : i_value;
        n_data.bcd = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> design/sitda_dd_stage.sv
// sitda_dd_stage: one double-dabble stage, shifts BITS_PER_STAGE magnitude bits into bcd
// depends on sitda_pkg
module sitda_dd_stage
    import sitda_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_conv i_data,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    output t_conv o_data
);

    logic  r_valid;
    t_conv r_data;
    t_conv n_data;
    logic [DIGITS*DIGIT_W-1:0] bcd_flat;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data   = i_data;
        bcd_flat = '0;
        for (int b = 0; b < BITS_PER_STAGE; b++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (n_data.bcd[d] >= DIGIT_W'(5)) begin
                    n_data.bcd[d] = n_data.bcd[d] + DIGIT_W'(3);
                end
            end
            bcd_flat   = n_data.bcd;
            n_data.bcd = {bcd_flat[DIGITS*DIGIT_W-2:0], n_data.bin[VALUE_W-1]};
            n_data.bin = {n_data.bin[VALUE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> design/sitda_len.sv
// sitda_len: counts significant digits and total text length
// depends on sitda_pkg
module sitda_len
    import sitda_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_conv i_data,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    output t_num  o_data
);

    logic r_valid;
    t_num r_data;
    t_num n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data.neg  = i_data.neg;
        n_data.bcd  = i_data.bcd;
        n_data.ndig = IDX_W'(1);
        // zero keeps one digit
        for (int d = 1; d < DIGITS; d++) begin
            if (i_data.bcd[d] != '0) begin
                n_data.ndig = IDX_W'(d + 1);
            end
        end
        n_data.len = LEN_W'(n_data.ndig) + LEN_W'(i_data.neg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> design/sitda_ser.sv
// sitda_ser: unless stalled, sends a number one character per cycle to the output register
// depends on sitda_pkg
module sitda_ser
    import sitda_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_num              i_num,
    output logic              o_ready,
    output logic              o_valid,
    output logic [CHAR_W-1:0] o_char_code,
    output logic              o_last,
    output logic [LEN_W-1:0]  o_length,
    input  logic              i_stall
);

    logic              r_busy;
    logic              r_sign_pend;
    logic [IDX_W-1:0]  r_idx;
    t_digits           r_bcd;
    logic [LEN_W-1:0]  r_len;

    logic              r_o_valid;
    logic [CHAR_W-1:0] r_o_char;
    logic              r_o_last;
    logic [LEN_W-1:0]  r_o_len;

    logic              out_load;
    logic              emit;
    logic              emit_last;
    logic [CHAR_W-1:0] cur_char;

    assign out_load  = !r_o_valid || !i_stall;
    assign emit      = out_load && r_busy;
    assign emit_last = emit && !r_sign_pend && (r_idx == '0);
    assign o_ready   = !r_busy || emit_last;

    assign cur_char = r_sign_pend ? CHAR_MINUS
                                  : (CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, r_bcd[r_idx]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_ready && i_valid) begin
            r_busy <= 1'b1;
        end else if (emit_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sign_pend <= i_num.neg;
            r_idx       <= i_num.ndig - IDX_W'(1);
            r_bcd       <= i_num.bcd;
            r_len       <= i_num.len;
        end else if (emit) begin
            if (r_sign_pend) begin
                r_sign_pend <= 1'b0;
            end else begin
                r_idx <= r_idx - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_char <= cur_char;
            r_o_last <= !r_sign_pend && (r_idx == '0);
            r_o_len  <= r_len;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_char_code = r_o_char;
    assign o_last      = r_o_last;
    assign o_length    = r_o_len;

endmodule

>>> design/signed_int_to_decimal_ascii_core.sv
// signed_int_to_decimal_ascii_core: signed 32-bit integer to decimal ascii text, top level
// depends on sitda_pkg, sitda_abs, sitda_dd_stage, sitda_len, sitda_ser
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+-------------------------------------
//  input    | in        | i_valid / o_stall | i_value[31:0] signed
//  output   | out       | o_valid / i_stall | o_char_code[7:0], o_last, o_length[3:0]
//
// a request enters a 10-stage pipeline (magnitude, eight double-dabble stages of four
// bits each, digit count) and can enter every cycle while the pipeline has room
// after the pipeline, a request is loaded into the serializer registers, each character into the output register
// the serializer then drives one character per cycle while i_stall is low, so a request occupies
// the output port for its text length, 1 to 11 characters; that port sets the sustained rate
// reset is synchronous, active low, and clears all valid flags
// a stall holds the output register and backs up the pipeline stage by stage;
// nothing is dropped or repeated
module signed_int_to_decimal_ascii_core
    import sitda_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_stall,
    output logic               o_valid,
    output logic [CHAR_W-1:0]  o_char_code,
    output logic               o_last,
    output logic [LEN_W-1:0]   o_length,
    input  logic               i_stall
);

    // stage k of the conversion chain: 0 is the magnitude stage, 1..DD_STAGES double-dabble
    logic  conv_valid [DD_STAGES+1];
    logic  conv_ready [DD_STAGES+1];
    t_conv conv_data  [DD_STAGES+1];

    logic  in_ready;
    logic  len_valid;
    logic  len_ready;
    t_num  len_data;

    // backpressure toward the request side
    assign o_stall = !in_ready;

    sitda_abs u_abs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_value (i_value),
        .o_ready (in_ready),
        .o_valid (conv_valid[0]),
        .i_ready (conv_ready[0]),
        .o_data  (conv_data[0])
    );

    // double-dabble chain, four magnitude bits per stage
    for (genvar s = 0; s < DD_STAGES; s++) begin : g_dd
        sitda_dd_stage u_dd (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (conv_valid[s]),
            .i_data  (conv_data[s]),
            .o_ready (conv_ready[s]),
            .o_valid (conv_valid[s+1]),
            .i_ready (conv_ready[s+1]),
            .o_data  (conv_data[s+1])
        );
    end

    sitda_len u_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (conv_valid[DD_STAGES]),
        .i_data  (conv_data[DD_STAGES]),
        .o_ready (conv_ready[DD_STAGES]),
        .o_valid (len_valid),
        .i_ready (len_ready),
        .o_data  (len_data)
    );

    // serializer with the output register acting as skid stage
    sitda_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (len_valid),
        .i_num       (len_data),
        .o_ready     (len_ready),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last),
        .o_length    (o_length),
        .i_stall     (i_stall)
    );

endmodule

>>> design/sitda_chk.sv
// sitda_chk: port-level checks on the output text stream, bound to the top level
// depends on sitda_pkg and signed_int_to_decimal_ascii_core
module sitda_chk
    import sitda_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic [CHAR_W-1:0] o_char_code,
    input logic              o_last,
    input logic [LEN_W-1:0]  o_length,
    input logic              i_stall
);

    // a stalled character holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_char_code) && $stable(o_last)
                               && $stable(o_length))
        else $error("stalled output changed");

    // text of one request is sent without gaps and with one length
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last && !i_stall |=> o_valid && (o_length == $past(o_length)))
        else $error("gap or length change inside a number");

    // final character is always a digit
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> (o_char_code >= CHAR_ZERO) && (o_char_code <= CHAR_ZERO + 8'd9))
        else $error("final character is not a digit");

    // a minus sign needs at least one digit after it
    a_minus_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_char_code == CHAR_MINUS) |-> !o_last && (o_length >= LEN_W'(2)))
        else $error("minus sign with bad length");

endmodule

bind signed_int_to_decimal_ascii_core sitda_chk u_sitda_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .o_char_code (o_char_code),
    .o_last      (o_last),
    .o_length    (o_length),
    .i_stall     (i_stall)
);
